// File: sv/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

	// Store geometry
	localparam int DEPTH = 1024;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Request and response field widths
	localparam int VALUE_W = 32;
	localparam int ELEMENT_COUNT_W = 11;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_BACK   = 2'd2,
		OP_POP_FRONT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RSVD  = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;  // request taken this cycle: update store and pointers
		logic load;    // move the finished result into the response register
	} dq_cmd_t;

	// Fold a position below 2*DEPTH back into the store
	function automatic logic [IDX_W-1:0] wrap_slot(input logic [CNT_W:0] pos);
		logic [CNT_W:0] lim;
		lim = (CNT_W + 1)'(DEPTH);
		if (pos >= lim) begin
			wrap_slot = IDX_W'(pos - lim);
		end else begin
			wrap_slot = IDX_W'(pos);
		end
	endfunction

endpackage

// File: sv/dq_if.sv
`timescale 1ns / 1ps

// Request channel
interface dq_req_if;
	import dq_pkg::*;

	logic                       valid;
	logic                       ready;
	op_t                        op;
	logic signed [VALUE_W-1:0]  push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink (input valid, input op, input push_value, output ready);
endinterface

// Response channel
interface dq_rsp_if;
	import dq_pkg::*;

	logic                               valid;
	logic                               ready;
	logic signed [VALUE_W-1:0]          pop_value;
	logic        [ELEMENT_COUNT_W-1:0]  element_count;
	status_t                            status;

	modport source (output valid, output pop_value, output element_count, output status,
		input ready);
	modport sink (input valid, input pop_value, input element_count, input status,
		output ready);
endinterface

// File: sv/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output dq_pkg::dq_cmd_t  cmd
);
	import dq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Handshake decode
	assign in_ready   = (state_q == S_IDLE);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.load   = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	// State and response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: sv/dq_datapath.sv
`timescale 1ns / 1ps

module dq_datapath (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  dq_pkg::dq_cmd_t                            cmd,
	input  dq_pkg::op_t                                op,
	input  logic signed [dq_pkg::VALUE_W-1:0]          push_value,
	output logic signed [dq_pkg::VALUE_W-1:0]          pop_value,
	output logic        [dq_pkg::ELEMENT_COUNT_W-1:0]  element_count,
	output dq_pkg::status_t                            status
);
	import dq_pkg::*;

	// Element store, no reset: only live entries are ever read
	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	// Per-request result held until the store read completes
	logic             pop_ok_q;
	logic [CNT_W-1:0] count_res_q;
	status_t          status_res_q;

	// Response register
	logic signed [VALUE_W-1:0]          pop_value_q;
	logic        [ELEMENT_COUNT_W-1:0]  element_count_q;
	status_t                            status_q;

	logic             full;
	logic             empty;
	logic [CNT_W:0]   back_sum;
	logic [IDX_W-1:0] back_slot;
	logic [IDX_W-1:0] last_slot;
	logic [IDX_W-1:0] head_prev;
	logic [IDX_W-1:0] head_succ;

	logic             we;
	logic             re;
	logic [IDX_W-1:0] addr;
	logic [IDX_W-1:0] head_d;
	logic [CNT_W-1:0] count_d;
	status_t          status_d;

	// Slot arithmetic
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign back_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
	assign back_slot = wrap_slot(back_sum);
	assign last_slot = wrap_slot(back_sum - (CNT_W + 1)'(1));
	assign head_prev = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
	assign head_succ = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

	// Request decode
	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		addr     = head_q;
		head_d   = head_q;
		count_d  = count_q;
		status_d = STAT_OK;
		unique case (op)
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					we      = 1'b1;
					addr    = back_slot;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					we      = 1'b1;
					addr    = head_prev;
					head_d  = head_prev;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					addr    = last_slot;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					addr    = head_q;
					head_d  = head_succ;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// Single-port store
	always_ff @(posedge clk) begin
		if (cmd.accept && we) begin
			mem[addr] <= push_value;
		end else if (cmd.accept && re) begin
			rd_data_q <= mem[addr];
		end
	end

	// Head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Result capture and response register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pop_ok_q     <= re;
			count_res_q  <= count_d;
			status_res_q <= status_d;
		end
		if (cmd.load) begin
			pop_value_q     <= pop_ok_q ? rd_data_q : '0;
			element_count_q <= ELEMENT_COUNT_W'(count_res_q);
			status_q        <= status_res_q;
		end
	end

	assign pop_value     = pop_value_q;
	assign element_count = element_count_q;
	assign status        = status_q;
endmodule

// File: sv/double_ended_queue_unit.sv
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit values in a 1024-entry circular store.
// Each request pushes or pops at either end and returns one response with the
// popped value (zero for pushes and errors), the element count after the
// request, and a status: ok, pop on empty, or push on full. A failed request
// leaves the queue unchanged. The store and the head/count pointers are updated
// when the request is accepted, and the popped value goes from the single-port
// store's registered read into the response register in the S_EXEC state. The
// next request is taken as soon as the previous result has moved into the
// response register, even while that response waits for ready. No clearing
// pass is needed after reset; the queue is empty at once.
module double_ended_queue_unit (
	input  logic       clk,
	input  logic       arst_n,
	dq_req_if.sink     req,
	dq_rsp_if.source   rsp
);
	import dq_pkg::*;

	dq_cmd_t cmd;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	dq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (req.op),
		.push_value    (req.push_value),
		.pop_value     (rsp.pop_value),
		.element_count (rsp.element_count),
		.status        (rsp.status)
	);
endmodule

// File: sv/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       req_valid,
	input  logic                                       req_ready,
	input  logic                                       rsp_valid,
	input  logic                                       rsp_ready,
	input  logic signed [dq_pkg::VALUE_W-1:0]          rsp_pop_value,
	input  logic        [dq_pkg::ELEMENT_COUNT_W-1:0]  rsp_element_count,
	input  dq_pkg::status_t                            rsp_status
);
	import dq_pkg::*;

	// Pop on empty reports an empty queue and no value
	a_empty_resp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_EMPTY |-> rsp_element_count == '0 && rsp_pop_value == '0)
		else $error("pop on empty with nonzero count or value");

	// Push on full reports a full queue and no value
	a_full_resp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_FULL
		|-> rsp_element_count == ELEMENT_COUNT_W'(DEPTH) && rsp_pop_value == '0)
		else $error("push on full with wrong count or nonzero value");

	// One request in flight: no back-to-back accepts
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted in consecutive cycles");

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pop_value)
		&& $stable(rsp_element_count) && $stable(rsp_status))
		else $error("stalled response changed");
endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_pop_value     (rsp.pop_value),
	.rsp_element_count (rsp.element_count),
	.rsp_status        (rsp.status)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dq_pkg::*;

	localparam int N_DIRECTED = 20;
	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_LIMIT = 2000;
	localparam int FILL_BURST = 3;

	typedef struct packed {
		logic signed [VALUE_W-1:0]          pop_value;
		logic        [ELEMENT_COUNT_W-1:0]  element_count;
		status_t                            status;
	} dq_result_t;

	// One request of the directed table; typed rows carry their own answer
	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  push_value;
		logic                       typed;
		dq_result_t                 result;
	} dq_row_t;

	localparam dq_result_t NO_RESULT = '{32'sd0, 11'd0, STAT_OK};

	logic clk;
	logic arst_n;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	double_ended_queue_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Directed requests: empty pops, extreme values, wrap of head below zero
	dq_row_t directed_rows [N_DIRECTED] = '{
		'{OP_POP_BACK,   32'sd0,           1'b1, '{32'sd0, 11'd0, STAT_EMPTY}},
		'{OP_POP_FRONT,  32'sd0,           1'b1, '{32'sd0, 11'd0, STAT_EMPTY}},
		'{OP_PUSH_BACK,  32'sh7FFFFFFF,    1'b1, '{32'sd0, 11'd1, STAT_OK}},
		'{OP_PUSH_FRONT, 32'sh80000000,    1'b1, '{32'sd0, 11'd2, STAT_OK}},
		'{OP_POP_BACK,   32'sd0,           1'b1, '{32'sh7FFFFFFF, 11'd1, STAT_OK}},
		'{OP_POP_FRONT,  32'sd0,           1'b1, '{32'sh80000000, 11'd0, STAT_OK}},
		'{OP_POP_FRONT,  32'sd0,           1'b1, '{32'sd0, 11'd0, STAT_EMPTY}},
		'{OP_PUSH_FRONT, 32'sd0,           1'b1, '{32'sd0, 11'd1, STAT_OK}},
		'{OP_PUSH_FRONT, -32'sd1,          1'b1, '{32'sd0, 11'd2, STAT_OK}},
		'{OP_PUSH_BACK,  32'sh55555555,    1'b1, '{32'sd0, 11'd3, STAT_OK}},
		'{OP_PUSH_BACK,  32'shAAAAAAAA,    1'b1, '{32'sd0, 11'd4, STAT_OK}},
		'{OP_POP_FRONT,  32'sd0,           1'b1, '{-32'sd1, 11'd3, STAT_OK}},
		'{OP_POP_BACK,   32'sd0,           1'b1, '{32'shAAAAAAAA, 11'd2, STAT_OK}},
		'{OP_POP_BACK,   32'sd0,           1'b1, '{32'sh55555555, 11'd1, STAT_OK}},
		'{OP_POP_BACK,   32'sd0,           1'b1, '{32'sd0, 11'd0, STAT_OK}},
		'{OP_POP_BACK,   32'sh7FFFFFFF,    1'b1, '{32'sd0, 11'd0, STAT_EMPTY}},
		'{OP_PUSH_BACK,  32'sd1,           1'b0, NO_RESULT},
		'{OP_PUSH_FRONT, 32'sh12345678,    1'b0, NO_RESULT},
		'{OP_POP_FRONT,  -32'sd1,          1'b0, NO_RESULT},
		'{OP_POP_BACK,   32'sd0,           1'b0, NO_RESULT}
	};

	// Shadow deque state
	logic signed [VALUE_W-1:0] shadow_store [DEPTH];
	int shadow_head = 0;
	int shadow_count = 0;

	dq_result_t predicted_responses [$];
	dq_result_t oldest;
	dq_result_t predicted;

	// Typed answer travels with the request it belongs to
	logic       row_typed;
	dq_result_t row_result;

	logic no_idle;
	int   stall_left;
	int   rsp_gap;
	int   quiet_cycles;
	int   mismatches;
	int   level;
	int   sent_random;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Deque behavior: update shadow state, return the response of one request
	function automatic dq_result_t apply_request(input op_t op,
		input logic signed [VALUE_W-1:0] value);
		dq_result_t r;
		int slot;
		r = NO_RESULT;
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					if (op == OP_PUSH_FRONT) begin
						shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
						slot = shadow_head;
					end else begin
						slot = (shadow_head + shadow_count) % DEPTH;
					end
					shadow_store[slot] = value;
					shadow_count++;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.status = STAT_EMPTY;
				end else if (op == OP_POP_FRONT) begin
					r.pop_value = shadow_store[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
				end else begin
					r.pop_value = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
					shadow_count--;
				end
			end
		endcase
		r.element_count = ELEMENT_COUNT_W'(shadow_count);
		return r;
	endfunction

	// Sender-side fill level, used only to steer the stimulus
	function automatic void track_level(input op_t op);
		if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
			if (level < DEPTH) begin
				level++;
			end
		end else if (level > 0) begin
			level--;
		end
	endfunction

	function automatic op_t pick_op(input int push_pct);
		logic at_front;
		at_front = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < push_pct) begin
			return at_front ? OP_PUSH_FRONT : OP_PUSH_BACK;
		end
		return at_front ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	function automatic logic signed [VALUE_W-1:0] random_value();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7FFFFFFF;
				1: return 32'sh80000000;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// Drive one request, hold it until taken, then maybe idle
	task automatic send_req(input op_t op, input logic signed [VALUE_W-1:0] value,
		input logic typed, input dq_result_t typed_result);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.push_value <= value;
		row_typed <= typed;
		row_result <= typed_result;
		do @(posedge clk); while (!req_ch.ready);
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input op_t op);
		send_req(op, random_value(), 1'b0, NO_RESULT);
		track_level(op);
		sent_random++;
	endtask

	// Stop sending until every outstanding response has come back
	task automatic wait_for_responses();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (predicted_responses.size() != 0) @(posedge clk);
	endtask

	// Response side: random backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_gap = no_idle ? 0 : pick_gap();
			stall_left <= rsp_gap;
			rsp_ch.ready <= (rsp_gap == 0);
		end
	end

	// Predict the response of each accepted request
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			predicted = apply_request(req_ch.op, req_ch.push_value);
			predicted_responses.push_back(row_typed ? row_result : predicted);
		end
	end

	// Compare each accepted response with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (predicted_responses.size() == 0) begin
				$error("response with no request outstanding");
				mismatches++;
			end else begin
				oldest = predicted_responses.pop_front();
				if (rsp_ch.pop_value !== oldest.pop_value) begin
					$error("pop_value: expected %0d, got %0d", oldest.pop_value,
						rsp_ch.pop_value);
					mismatches++;
				end
				if (rsp_ch.element_count !== oldest.element_count) begin
					$error("element_count: expected %0d, got %0d", oldest.element_count,
						rsp_ch.element_count);
					mismatches++;
				end
				if (rsp_ch.status !== oldest.status) begin
					$error("status: expected %0d, got %0d", oldest.status, rsp_ch.status);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		int burst;
		int push_pct;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PUSH_BACK;
		req_ch.push_value = '0;
		rsp_ch.ready = 1'b0;
		row_typed = 1'b0;
		row_result = NO_RESULT;
		no_idle = 1'b0;
		stall_left = 0;
		quiet_cycles = 0;
		mismatches = 0;
		level = 0;
		sent_random = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_req(directed_rows[i].op, directed_rows[i].push_value,
				directed_rows[i].typed, directed_rows[i].result);
			track_level(directed_rows[i].op);
		end
		wait_for_responses();

		// Random bursts: balanced, growing, shrinking, and one fill past full
		burst = 0;
		while (sent_random < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if (burst == FILL_BURST) begin
				while (level < DEPTH) send_random(pick_op(100));
				repeat ($urandom_range(4, 10)) send_random(pick_op(100));
				repeat ($urandom_range(4, 10)) send_random(pick_op(0));
			end else begin
				case ($urandom_range(0, 2))
					0: push_pct = 50;
					1: push_pct = 80;
					default: push_pct = 20;
				endcase
				repeat ($urandom_range(8, 60)) send_random(pick_op(push_pct));
			end
			if (burst % 5 == 4) begin
				wait_for_responses();
			end
			burst++;
		end

		wait_for_responses();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
